@@ rtl/srb_pkg.sv @@
package srb_pkg;

  // Fixed field widths of the item and result words
  localparam int unsigned SeqWidth  = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned OccWidth  = 9;

  // Default sizing of the store
  localparam int unsigned CapacityDefault     = 256;
  localparam int unsigned PayloadWidthDefault = 32;

  // Valid bits are kept in rows of sixteen slots
  localparam int unsigned RowIdxBits = 4;
  localparam int unsigned RowBits    = 1 << RowIdxBits;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic                  found;
    logic [RowIdxBits-1:0] idx;
  } ffs_t;

  // Find the lowest set bit of one valid row
  function automatic ffs_t first_set(logic [RowBits-1:0] row);
    ffs_t r;
    r = '0;
    for (int i = RowBits - 1; i >= 0; i--) begin
      if (row[i]) begin
        r.found = 1'b1;
        r.idx   = RowIdxBits'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/srb_if.sv @@
interface srb_item_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [srb_pkg::SeqWidth-1:0]  seq_index;
  logic [srb_pkg::DataWidth-1:0] payload;

  modport source (output valid, cmd, seq_index, payload, input ready);
  modport sink   (input valid, cmd, seq_index, payload, output ready);
endinterface

interface srb_result_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          hit;
  logic [srb_pkg::DataWidth-1:0] data;
  logic [srb_pkg::OccWidth-1:0]  occupancy;
  logic [srb_pkg::SeqWidth-1:0]  window_start;

  modport source (output valid, status, hit, data, occupancy, window_start, input ready);
  modport sink   (input valid, status, hit, data, occupancy, window_start, output ready);
endinterface

@@ rtl/sequence_reorder_buffer.sv @@
// Sequence-number reorder buffer. Each accepted word is an insert, lookup, remove or
// no-op at a 16-bit sequence number and yields one result word. Valid bits live in a
// synchronous memory of CAPACITY/16 rows of sixteen bits, payloads in a CAPACITY-deep
// memory; an item is accepted with a memory read, then handled by a read-modify-write.
// Removing the entry at the window start moves the cursor: the rest of its own row is
// searched in the same cycle, and each further row is then read from the valid memory
// in turn until a set bit is found. A finished result waits in an output register while
// the next word is taken. After reset a clearing pass zeroes the valid rows before the
// first word is accepted.
module sequence_reorder_buffer #(
  parameter int unsigned CAPACITY      = srb_pkg::CapacityDefault,
  parameter int unsigned PAYLOAD_WIDTH = srb_pkg::PayloadWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  srb_item_if.sink     in_i,
  srb_result_if.source out_o
);

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned Rows  = CAPACITY / srb_pkg::RowBits;
  localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned RbW   = srb_pkg::RowBits;
  localparam int unsigned SqW   = srb_pkg::SeqWidth;
  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);

  // Memories
  logic [RbW-1:0]           vmem [Rows];
  logic [PAYLOAD_WIDTH-1:0] pmem [CAPACITY];

  logic                     v_rd_en, v_wr_en, p_rd_en, p_wr_en;
  logic [RowW-1:0]          v_rd_addr, v_wr_addr;
  logic [RbW-1:0]           v_wr_data, v_rd_q;
  logic [SlotW-1:0]         p_rd_addr, p_wr_addr;
  logic [PAYLOAD_WIDTH-1:0] p_wr_data, p_rd_q;

  // Control and item registers
  srb_pkg::state_e          state_q, state_d;
  logic [SqW-1:0]           cursor_q, cursor_d;
  logic [CntW-1:0]          count_q, count_d;
  logic [RowW-1:0]          row_q, row_d;
  logic [RbW-1:0]           mod_row_q, mod_row_d;
  logic [RowW-1:0]          mod_addr_q, mod_addr_d;
  srb_pkg::cmd_e            cmd_q;
  logic [SqW-1:0]           seq_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic                     ok_q, ok_in;

  // Result register
  logic                         out_valid_q;
  logic                         status_q, hit_q;
  logic [srb_pkg::DataWidth-1:0] data_q;
  logic [srb_pkg::OccWidth-1:0]  occ_q;
  logic [SqW-1:0]               win_q;
  logic                         res_load, res_fire, out_free;

  // Accept side
  logic                 acc, empty, in_win;
  srb_pkg::cmd_e        in_cmd;
  logic [SqW-1:0]       in_off;
  logic [SlotW-1:0]     in_slot;

  // Access side
  logic [SlotW-1:0]     slot_a, found_a, found_s, dist_a, dist_s;
  logic [RowW-1:0]      row_a, row_a_nxt, row_q_nxt;
  logic [srb_pkg::RowIdxBits-1:0] bit_a;
  logic [RbW-1:0]       onehot_a, new_row, above_mask, scan_row;
  logic                 vhit, need_scan, cnt_after_nz;
  srb_pkg::ffs_t        above, scan_hit;

  assign acc      = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == srb_pkg::ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  // Window check on the incoming word
  assign in_cmd  = srb_pkg::cmd_e'(in_i.cmd);
  assign empty   = (count_q == '0);
  assign in_off  = in_i.seq_index - cursor_q;
  assign in_win  = {1'b0, in_off} < (SqW + 1)'(CAPACITY);
  assign in_slot = SlotW'(in_i.seq_index);

  always_comb begin
    unique case (in_cmd) inside
      srb_pkg::CMD_INSERT:                     ok_in = empty || in_win;
      srb_pkg::CMD_LOOKUP, srb_pkg::CMD_REMOVE: ok_in = !empty && in_win;
      default:                                 ok_in = 1'b0;
    endcase
  end

  // Slot decode and row update for the held word
  assign slot_a     = SlotW'(seq_q);
  assign row_a      = RowW'(slot_a >> srb_pkg::RowIdxBits);
  assign bit_a      = slot_a[srb_pkg::RowIdxBits-1:0];
  assign onehot_a   = RbW'(1) << bit_a;
  assign vhit       = ok_q && v_rd_q[bit_a];
  assign new_row    = (cmd_q == srb_pkg::CMD_INSERT) ? (v_rd_q | onehot_a)
                                                    : (v_rd_q & ~onehot_a);
  assign above_mask = ~((onehot_a << 1) - RbW'(1));
  assign above      = srb_pkg::first_set(new_row & above_mask);
  assign row_a_nxt  = (row_a == LastRow) ? '0 : row_a + RowW'(1);
  assign row_q_nxt  = (row_q == LastRow) ? '0 : row_q + RowW'(1);

  assign cnt_after_nz = !((count_q == CntW'(1)) && vhit);
  assign need_scan    = ok_q && (cmd_q == srb_pkg::CMD_REMOVE) && (seq_q == cursor_q)
                        && cnt_after_nz && !empty;

  // Forward the row rewritten in the access cycle into the scan
  assign scan_row = (row_q == mod_addr_q) ? mod_row_q : v_rd_q;
  assign scan_hit = srb_pkg::first_set(scan_row);

  assign found_a = SlotW'({row_a, above.idx});
  assign dist_a  = found_a - slot_a;
  assign found_s = SlotW'({row_q, scan_hit.idx});
  assign dist_s  = found_s - SlotW'(cursor_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srb_pkg::ST_CLEAR: begin
        if (row_q == LastRow) state_d = srb_pkg::ST_IDLE;
      end
      srb_pkg::ST_IDLE: begin
        if (acc) state_d = srb_pkg::ST_ACCESS;
      end
      srb_pkg::ST_ACCESS: begin
        if (out_free) begin
          state_d = (need_scan && !above.found) ? srb_pkg::ST_SCAN : srb_pkg::ST_IDLE;
        end
      end
      srb_pkg::ST_SCAN: begin
        if (scan_hit.found) state_d = srb_pkg::ST_IDLE;
      end
      default: state_d = srb_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses and state updates
  always_comb begin
    v_rd_en    = 1'b0;
    v_rd_addr  = row_q;
    v_wr_en    = 1'b0;
    v_wr_addr  = row_a;
    v_wr_data  = new_row;
    p_rd_en    = 1'b0;
    p_rd_addr  = in_slot;
    p_wr_en    = 1'b0;
    p_wr_addr  = slot_a;
    p_wr_data  = pay_q;
    cursor_d   = cursor_q;
    count_d    = count_q;
    row_d      = row_q;
    mod_row_d  = mod_row_q;
    mod_addr_d = mod_addr_q;
    res_load   = 1'b0;
    res_fire   = 1'b0;
    unique case (state_q)
      srb_pkg::ST_CLEAR: begin
        v_wr_en   = 1'b1;
        v_wr_addr = row_q;
        v_wr_data = '0;
        row_d     = row_q_nxt;
      end
      srb_pkg::ST_IDLE: begin
        if (acc) begin
          v_rd_en   = 1'b1;
          v_rd_addr = RowW'(in_slot >> srb_pkg::RowIdxBits);
          p_rd_en   = 1'b1;
        end
      end
      srb_pkg::ST_ACCESS: begin
        if (out_free) begin
          res_load = 1'b1;
          v_wr_en  = ok_q && (cmd_q != srb_pkg::CMD_LOOKUP);
          p_wr_en  = ok_q && (cmd_q == srb_pkg::CMD_INSERT);
          if (ok_q && (cmd_q == srb_pkg::CMD_INSERT)) begin
            if (empty) cursor_d = seq_q;
            if (!vhit) count_d = count_q + CntW'(1);
          end
          if (ok_q && (cmd_q == srb_pkg::CMD_REMOVE) && vhit) begin
            count_d = count_q - CntW'(1);
          end
          if (need_scan) begin
            if (above.found) begin
              cursor_d = cursor_q + SqW'(dist_a);
              res_fire = 1'b1;
            end else begin
              v_rd_en    = 1'b1;
              v_rd_addr  = row_a_nxt;
              row_d      = row_a_nxt;
              mod_row_d  = new_row;
              mod_addr_d = row_a;
            end
          end else begin
            res_fire = 1'b1;
          end
        end
      end
      srb_pkg::ST_SCAN: begin
        if (scan_hit.found) begin
          cursor_d = cursor_q + SqW'(dist_s);
          res_fire = 1'b1;
        end else begin
          v_rd_en   = 1'b1;
          v_rd_addr = row_q_nxt;
          row_d     = row_q_nxt;
        end
      end
      default: ;
    endcase
  end

  // Valid-row memory
  always_ff @(posedge clk_i) begin
    if (v_wr_en) vmem[v_wr_addr] <= v_wr_data;
    if (v_rd_en) v_rd_q <= vmem[v_rd_addr];
  end

  // Payload memory
  always_ff @(posedge clk_i) begin
    if (p_wr_en) pmem[p_wr_addr] <= p_wr_data;
    if (p_rd_en) p_rd_q <= pmem[p_rd_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srb_pkg::ST_CLEAR;
      cursor_q    <= '0;
      count_q     <= '0;
      row_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      row_q    <= row_d;
      if (acc) ok_q <= ok_in;
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload registers
  always_ff @(posedge clk_i) begin
    mod_row_q  <= mod_row_d;
    mod_addr_q <= mod_addr_d;
    if (acc) begin
      cmd_q <= in_cmd;
      seq_q <= in_i.seq_index;
      pay_q <= PAYLOAD_WIDTH'(in_i.payload);
    end
    if (res_load) begin
      status_q <= !ok_q;
      hit_q    <= vhit;
      data_q   <= vhit ? srb_pkg::DataWidth'(p_rd_q) : '0;
      occ_q    <= srb_pkg::OccWidth'(count_d);
    end
    if (res_load || res_fire) win_q <= cursor_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.hit          = hit_q;
  assign out_o.data         = data_q;
  assign out_o.occupancy    = occ_q;
  assign out_o.window_start = win_q;

endmodule

@@ rtl/srb_checker.sv @@
module srb_checker #(
  parameter int unsigned CAPACITY = srb_pkg::CapacityDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_status_i,
  input logic                          out_hit_i,
  input logic [srb_pkg::DataWidth-1:0] out_data_i,
  input logic [srb_pkg::OccWidth-1:0]  out_occupancy_i
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)
      && $stable(out_hit_i) && $stable(out_occupancy_i))
    else $error("result word changed while stalled");

  // One word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("word accepted while previous one in access");

  // Rejected words carry no occupant
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i |-> !out_hit_i && (out_data_i == '0))
    else $error("rejected word reports an occupant");

  // Miss returns zero data
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_hit_i |-> (out_data_i == '0))
    else $error("miss returns nonzero data");

  // Occupancy never exceeds the store size (checked only for CAPACITY below 512)
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (CAPACITY >= 512) || (32'(out_occupancy_i) <= CAPACITY))
    else $error("occupancy above capacity");

endmodule

bind sequence_reorder_buffer srb_checker #(
  .CAPACITY (CAPACITY)
) u_srb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_hit_i       (out_o.hit),
  .out_data_i      (out_o.data),
  .out_occupancy_i (out_o.occupancy)
);
